### hw/rtl/msb_first_code_bit_packer_unit_defines.svh
// Assertion macros shared by the bit packer RTL.
// No dependencies; files that check their own logic include this header.
`ifndef MSB_FIRST_CODE_BIT_PACKER_UNIT_DEFINES_SVH
`define MSB_FIRST_CODE_BIT_PACKER_UNIT_DEFINES_SVH

// Checks that a condition holds on every clock edge out of reset.
`define MSBPK_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that a trigger is followed in the same cycle by a consequence.
`define MSBPK_ASSERT_IMP(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error(msg);

// Checks that a trigger is followed in the next cycle by a consequence.
`define MSBPK_ASSERT_NXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/msbpk_pkg.sv
// Shared types and constants for the MSB-first code bit packer.
// No dependencies; the interfaces and modules of the block import this package.
package msbpk_pkg;

  localparam int unsigned VALUE_W          = 32;
  localparam int unsigned LEN_W            = 6;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned TOTAL_W          = 32;
  localparam int unsigned MAX_CODE_LEN_DEF = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_FLUSH
  } msbpk_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic emit_byte;
    logic emit_final;
  } msbpk_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic code_has_byte;
    logic more_bytes;
    logic slot_free;
  } msbpk_sts_t;

endpackage

### hw/rtl/msbpk_in_if.sv
// Input channel of the bit packer: one code or one flush per beat.
// Depends on msbpk_pkg for the field widths.
interface msbpk_in_if;
  import msbpk_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] code_value;
  logic [LEN_W-1:0]   code_len;
  logic               flush;

  modport source (output valid, output code_value, output code_len, output flush,
                  input ready);
  modport sink   (input valid, input code_value, input code_len, input flush,
                  output ready);
endinterface

### hw/rtl/msbpk_out_if.sv
// Output channel of the bit packer: one packed byte or final report per beat.
// Depends on msbpk_pkg for the field widths.
interface msbpk_out_if;
  import msbpk_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  data_byte;
  logic               byte_valid;
  logic               is_final;
  logic [TOTAL_W-1:0] bit_total;

  modport source (output valid, output data_byte, output byte_valid, output is_final,
                  output bit_total, input ready);
  modport sink   (input valid, input data_byte, input byte_valid, input is_final,
                  input bit_total, output ready);
endinterface

### hw/rtl/msbpk_ctrl.sv
// Controller state machine of the bit packer: input handshake and byte sequencing.
// Depends on msbpk_pkg for the state enum and the command and status structs.
module msbpk_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_flush_i,
  output logic                    in_ready_o,
  input  msbpk_pkg::msbpk_sts_t   sts_i,
  output msbpk_pkg::msbpk_cmd_t   cmd_o
);
  import msbpk_pkg::*;

  msbpk_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_flush_i) begin
            if (!sts_i.slot_free) begin
              state_d = ST_FLUSH;
            end
          end else if (sts_i.code_has_byte) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (sts_i.slot_free && !sts_i.more_bytes) begin
          state_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (sts_i.slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_flush_i) begin
            cmd_o.emit_final = sts_i.slot_free;
          end else begin
            cmd_o.accept = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        cmd_o.emit_byte = sts_i.slot_free;
      end
      ST_FLUSH: begin
        cmd_o.emit_final = sts_i.slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### hw/rtl/msbpk_datapath.sv
// Datapath of the bit packer: bit accumulator, bit counters and output register.
// Depends on msbpk_pkg and on the assertion macros in the defines header.
`include "msb_first_code_bit_packer_unit_defines.svh"

module msbpk_datapath #(
  parameter int unsigned MAX_CODE_LEN = msbpk_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [msbpk_pkg::VALUE_W-1:0]   code_value_i,
  input  logic [msbpk_pkg::LEN_W-1:0]     code_len_i,
  input  msbpk_pkg::msbpk_cmd_t           cmd_i,
  output msbpk_pkg::msbpk_sts_t           sts_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [msbpk_pkg::BYTE_W-1:0]    data_byte_o,
  output logic                            byte_valid_o,
  output logic                            is_final_o,
  output logic [msbpk_pkg::TOTAL_W-1:0]   bit_total_o
);
  import msbpk_pkg::*;

  // Longest code the block takes, and the accumulator that holds it plus the
  // up to seven pending bits of the previous codes. The bit count is wide
  // enough to hold the two-byte threshold even for short code limits.
  localparam int unsigned LIMIT_LEN = (MAX_CODE_LEN < VALUE_W) ? MAX_CODE_LEN : VALUE_W;
  localparam int unsigned ACC_W     = BYTE_W - 1 + LIMIT_LEN;
  localparam int unsigned CNT_W     = $clog2(ACC_W + BYTE_W + 1);
  localparam int unsigned PAD_W     = $clog2(BYTE_W + 1);
  localparam int unsigned PART_W    = $clog2(BYTE_W);

  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [TOTAL_W-1:0] total_q, total_d;

  logic               out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]  out_byte_q, out_byte_d;
  logic               out_bvalid_q, out_bvalid_d;
  logic               out_final_q, out_final_d;
  logic [TOTAL_W-1:0] out_total_q, out_total_d;

  logic [LEN_W-1:0]   len_eff;
  logic [VALUE_W-1:0] value_mask;
  logic [ACC_W-1:0]   part_mask;
  logic [ACC_W-1:0]   acc_new;
  logic [CNT_W-1:0]   cnt_new;
  logic [TOTAL_W:0]   total_sum;
  logic [BYTE_W-1:0]  next_byte;
  logic [BYTE_W-1:0]  pad_byte;
  logic [PART_W-1:0]  part_cnt;
  logic               slot_free;

  assign part_cnt = cnt_q[PART_W-1:0];

  // Clamp the length and drop value bits above it.
  assign len_eff    = (code_len_i > LEN_W'(LIMIT_LEN)) ? LEN_W'(LIMIT_LEN) : code_len_i;
  assign value_mask = {VALUE_W{1'b1}} >> (LEN_W'(VALUE_W) - len_eff);

  // Append the new code below the pending bits.
  assign part_mask = ~({ACC_W{1'b1}} << part_cnt);
  assign acc_new   = ((acc_q & part_mask) << len_eff) | ACC_W'(code_value_i & value_mask);
  assign cnt_new   = CNT_W'(part_cnt) + CNT_W'(len_eff);
  assign total_sum = {1'b0, total_q} + (TOTAL_W + 1)'(len_eff);

  // Oldest complete byte, and the zero-padded pending byte for a flush.
  assign next_byte = BYTE_W'(acc_q >> (cnt_q - CNT_W'(BYTE_W)));
  assign pad_byte  = BYTE_W'(acc_q[BYTE_W-1:0] << (PAD_W'(BYTE_W) - PAD_W'(part_cnt)));

  assign slot_free = !out_valid_q || out_ready_i;

  assign sts_o.code_has_byte = (cnt_new >= CNT_W'(BYTE_W));
  assign sts_o.more_bytes    = (cnt_q >= CNT_W'(2 * BYTE_W));
  assign sts_o.slot_free     = slot_free;

  always_comb begin
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    total_d = total_q;
    if (cmd_i.accept) begin
      acc_d   = acc_new;
      cnt_d   = cnt_new;
      total_d = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];
    end else if (cmd_i.emit_byte) begin
      cnt_d = cnt_q - CNT_W'(BYTE_W);
    end else if (cmd_i.emit_final) begin
      cnt_d   = '0;
      total_d = '0;
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q && !out_ready_i;
    out_byte_d   = out_byte_q;
    out_bvalid_d = out_bvalid_q;
    out_final_d  = out_final_q;
    out_total_d  = out_total_q;
    if (cmd_i.emit_byte) begin
      out_valid_d  = 1'b1;
      out_byte_d   = next_byte;
      out_bvalid_d = 1'b1;
      out_final_d  = 1'b0;
      out_total_d  = '0;
    end else if (cmd_i.emit_final) begin
      out_valid_d  = 1'b1;
      out_byte_d   = pad_byte;
      out_bvalid_d = (part_cnt != '0);
      out_final_d  = 1'b1;
      out_total_d  = total_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q        <= acc_d;
    out_byte_q   <= out_byte_d;
    out_bvalid_q <= out_bvalid_d;
    out_final_q  <= out_final_d;
    out_total_q  <= out_total_d;
  end

  assign out_valid_o  = out_valid_q;
  assign data_byte_o  = out_byte_q;
  assign byte_valid_o = out_bvalid_q;
  assign is_final_o   = out_final_q;
  assign bit_total_o  = out_total_q;

  `MSBPK_ASSERT_IMP(a_load_needs_slot, cmd_i.emit_byte || cmd_i.emit_final, slot_free,
    "result loaded while the output register still holds an untaken beat")
  `MSBPK_ASSERT_IMP(a_accept_partial_only, cmd_i.accept, cnt_q < CNT_W'(BYTE_W),
    "code accepted while complete bytes are still pending")
  `MSBPK_ASSERT_NXT(a_final_clears, cmd_i.emit_final, cnt_q == '0 && total_q == '0,
    "stream state not cleared after a flush")
  `MSBPK_ASSERT_IMP(a_byte_has_no_total, out_valid_q && !out_final_q,
    out_bvalid_q && out_total_q == '0, "non-final beat carries a bit total or no byte")

endmodule

### hw/rtl/msb_first_code_bit_packer_unit.sv
// A code is taken in the idle state; the emit state then loads its complete bytes.
// A code completes 0 to 4 bytes; no new code is taken until all are loaded.
// The single byte extractor emits one byte per cycle while the output is free.
// A stalled output holds its beat; a code is taken while the last result still waits.
// Reset (rst_ni low, asynchronous) empties the partial byte, bit total and output.
//
// Top level of the MSB-first code bit packer. Depends on msbpk_pkg, the two
// channel interfaces, msbpk_ctrl and msbpk_datapath.
module msb_first_code_bit_packer_unit #(
  parameter int unsigned MAX_CODE_LEN = msbpk_pkg::MAX_CODE_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  msbpk_in_if.sink    code_i,
  msbpk_out_if.source byte_o
);
  import msbpk_pkg::*;

  // The controller owns the input handshake and decides when the datapath
  // appends a code, pulls one byte from its accumulator or reports the end of
  // a stream. The datapath tells it whether the offered code completes a byte,
  // whether more bytes are pending and whether the output register is free.
  msbpk_cmd_t cmd;
  msbpk_sts_t sts;
  logic       in_ready;

  msbpk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (code_i.valid),
    .in_flush_i (code_i.flush),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath keeps pending code bits right aligned in an accumulator wide
  // enough for seven leftover bits plus the longest code, so a code never has
  // to wait for room. The output register decouples the two channels.
  msbpk_datapath #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .code_value_i  (code_i.code_value),
    .code_len_i    (code_i.code_len),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (byte_o.ready),
    .out_valid_o   (byte_o.valid),
    .data_byte_o   (byte_o.data_byte),
    .byte_valid_o  (byte_o.byte_valid),
    .is_final_o    (byte_o.is_final),
    .bit_total_o   (byte_o.bit_total)
  );

  assign code_i.ready = in_ready;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for msb_first_code_bit_packer_unit: random and directed codes and
// flushes, with beats checked against an in-bench bit packing tracker.
// Depends on msbpk_pkg, msbpk_in_if, msbpk_out_if and the packer RTL.
module testbench;
  import msbpk_pkg::*;

  // The block is built with its default code length limit. Lengths above the
  // limit, or above the width of the value field, are clipped to the smaller.
  localparam int unsigned MAX_LEN       = MAX_CODE_LEN_DEF;
  localparam int unsigned CODE_LIMIT    = (MAX_LEN < VALUE_W) ? MAX_LEN : VALUE_W;
  // Cycles with no beat on either channel before the run is declared hung.
  localparam int unsigned QUIET_LIMIT   = 2000;
  // Cycles to keep watching the output once every expected beat has arrived.
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned RANDOM_ITEMS  = 130;

  // One output beat as the tracker expects to see it.
  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic               byte_valid;
    logic               is_final;
    logic [TOTAL_W-1:0] bit_total;
  } packed_beat_t;

  // Tracks the packer's partial byte and bit total, and keeps the beats that
  // each accepted code or flush must produce, oldest first.
  class packed_byte_tracker;
    logic [6:0]         held_bits;
    int unsigned        held_count;
    logic [TOTAL_W-1:0] stream_bits;
    packed_beat_t       owed_beats[$];
    int unsigned        mismatches;

    function new();
      held_bits   = '0;
      held_count  = 0;
      stream_bits = '0;
      mismatches  = 0;
    endfunction

    function int unsigned pending();
      return owed_beats.size();
    endfunction

    // Called once per accepted input beat.
    function void absorb_code(input logic [VALUE_W-1:0] value,
                              input logic [LEN_W-1:0] length, input logic flush);
      packed_beat_t beat;
      int unsigned  eff_len;
      int unsigned  avail;
      logic [63:0]  acc;
      logic [15:0]  padded;
      logic [32:0]  sum;
      if (flush) begin
        padded          = 16'(held_bits) << (BYTE_W - held_count);
        beat.data_byte  = (held_count != 0) ? padded[BYTE_W-1:0] : '0;
        beat.byte_valid = (held_count != 0);
        beat.is_final   = 1'b1;
        beat.bit_total  = stream_bits;
        owed_beats.push_back(beat);
        held_bits   = '0;
        held_count  = 0;
        stream_bits = '0;
        return;
      end
      eff_len = (length > CODE_LIMIT) ? CODE_LIMIT : length;
      if (eff_len == 0) return;
      // Append the code below the pending bits, then peel off whole bytes from the top.
      acc   = (64'(held_bits) << eff_len) | (64'(value) & ((64'd1 << eff_len) - 64'd1));
      avail = held_count + eff_len;
      while (avail >= BYTE_W) begin
        beat.data_byte  = BYTE_W'(acc >> (avail - BYTE_W));
        beat.byte_valid = 1'b1;
        beat.is_final   = 1'b0;
        beat.bit_total  = '0;
        owed_beats.push_back(beat);
        avail -= BYTE_W;
      end
      held_count = avail;
      held_bits  = 7'(acc & ((64'd1 << avail) - 64'd1));
      // The bit total saturates instead of wrapping.
      sum         = 33'(stream_bits) + 33'(eff_len);
      stream_bits = sum[32] ? '1 : sum[TOTAL_W-1:0];
    endfunction

    // Called once per accepted output beat.
    function void check_beat(input logic [BYTE_W-1:0] data_byte, input logic byte_valid,
                             input logic is_final, input logic [TOTAL_W-1:0] bit_total);
      packed_beat_t want;
      if (owed_beats.size() == 0) begin
        $error("unexpected output beat: data_byte %0h is_final %0b", data_byte, is_final);
        mismatches++;
        return;
      end
      want = owed_beats.pop_front();
      if (data_byte !== want.data_byte) begin
        $error("data_byte mismatch: expected %0h, actual %0h", want.data_byte, data_byte);
        mismatches++;
      end
      if (byte_valid !== want.byte_valid) begin
        $error("byte_valid mismatch: expected %0b, actual %0b", want.byte_valid, byte_valid);
        mismatches++;
      end
      if (is_final !== want.is_final) begin
        $error("is_final mismatch: expected %0b, actual %0b", want.is_final, is_final);
        mismatches++;
      end
      if (bit_total !== want.bit_total) begin
        $error("bit_total mismatch: expected %0d, actual %0d", want.bit_total, bit_total);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  // Chance, in percent, that the sender or the receiver sits out a cycle.
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned quiet_cycles;
  bit          timed_out;

  packed_byte_tracker tracker;

  msbpk_in_if  code_if ();
  msbpk_out_if byte_if ();

  msb_first_code_bit_packer_unit #(
    .MAX_CODE_LEN(MAX_LEN)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .code_i(code_if),
    .byte_o(byte_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver drops ready at random. With the idle chance at zero it takes
  // a beat on every cycle.
  always @(posedge clk_i) begin
    byte_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Both channels are sampled at the rising edge, before any of this edge's
  // updates land. The same block doubles as the hang watchdog: it counts
  // cycles in which neither channel moves a beat.
  always @(posedge clk_i) begin
    if (rst_ni && code_if.valid && code_if.ready)
      tracker.absorb_code(code_if.code_value, code_if.code_len, code_if.flush);
    if (rst_ni && byte_if.valid && byte_if.ready)
      tracker.check_beat(byte_if.data_byte, byte_if.byte_valid, byte_if.is_final,
                         byte_if.bit_total);
    if ((code_if.valid && code_if.ready) || (byte_if.valid && byte_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT && !timed_out) begin
      timed_out <= 1'b1;
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offers one beat on the code channel and returns at the edge that takes it.
  // Valid is left high on return, so a following beat with no idle cycle in
  // between needs only new field values, never a drop and rise of valid.
  task automatic send_code(input logic [VALUE_W-1:0] value, input logic [LEN_W-1:0] length,
                           input logic flush);
    while ($urandom_range(99) < src_idle_pct) begin
      code_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    code_if.valid      <= 1'b1;
    code_if.code_value <= value;
    code_if.code_len   <= length;
    code_if.flush      <= flush;
    @(posedge clk_i);
    while (!code_if.ready) @(posedge clk_i);
  endtask

  // Holds the code channel idle until every owed beat has been taken. The
  // tracker is read on the falling edge, clear of the rising-edge monitor.
  task automatic wait_for_drain();
    code_if.valid <= 1'b0;
    @(negedge clk_i);
    while (tracker.pending() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // One random beat. Most are typical short codes; the rest cover long codes,
  // zero lengths, overlong lengths that must clip, and flushes that close a
  // stream. Values are always fully random, so stray high bits are frequent.
  task automatic send_random_item();
    int unsigned        pick;
    logic [VALUE_W-1:0] value;
    logic [LEN_W-1:0]   length;
    pick  = $urandom_range(99);
    value = $urandom;
    if (pick < 8) begin
      send_code(value, LEN_W'($urandom_range(63)), 1'b1);
    end else begin
      if (pick < 13)      length = '0;
      else if (pick < 20) length = LEN_W'($urandom_range(63, CODE_LIMIT + 1));
      else if (pick < 35) length = LEN_W'($urandom_range(CODE_LIMIT, 24));
      else                length = LEN_W'($urandom_range(12, 1));
      send_code(value, length, 1'b0);
    end
  endtask

  initial begin
    tracker            = new();
    timed_out          = 1'b0;
    quiet_cycles       = 0;
    src_idle_pct       = 25;
    sink_idle_pct      = 25;
    rst_ni             = 1'b0;
    code_if.valid      = 1'b0;
    code_if.code_value = '0;
    code_if.code_len   = '0;
    code_if.flush      = 1'b0;
    byte_if.ready      = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A single bit, then a full byte that straddles it.
    send_code(32'h0000_0001, 6'd1, 1'b0);
    send_code(32'h0000_00A5, 6'd8, 1'b0);
    // Widest codes, all ones and all zeros.
    send_code(32'hFFFF_FFFF, 6'd32, 1'b0);
    send_code(32'h0000_0000, 6'd32, 1'b0);
    // A zero-length code adds nothing, even with every value bit set.
    send_code(32'hFFFF_FFFF, 6'd0, 1'b0);
    // Value bits above the length must be dropped.
    send_code(32'hFFFF_FFD5, 6'd7, 1'b0);
    // Flush with no bits pending but a nonzero bit total, then a flush of an empty
    // stream, then a flush whose code fields are set and must be ignored.
    send_code(32'h0000_0000, 6'd0, 1'b1);
    send_code(32'h0000_0000, 6'd0, 1'b1);
    send_code(32'hFFFF_FFFF, 6'd63, 1'b1);
    // Seven pending bits plus a 32-bit code: the most bytes one code can give.
    send_code(32'h0000_007F, 6'd7, 1'b0);
    send_code(32'hDEAD_BEEF, 6'd32, 1'b0);
    // Lengths past the limit clip to it.
    send_code(32'h1234_5678, 6'd63, 1'b0);
    send_code(32'hCAFE_F00D, 6'd33, 1'b0);
    send_code(32'h0000_0005, 6'd3, 1'b0);
    send_code(32'h0000_0000, 6'd0, 1'b1);
    send_code(32'h8000_0000, 6'd32, 1'b0);
    send_code(32'h5555_AAAA, 6'd40, 1'b0);
    send_code(32'h0000_0001, 6'd5, 1'b0);
    send_code(32'hFFFF_FFFF, 6'd0, 1'b1);
    wait_for_drain();

    // Random part, with a stretch in the middle where neither side idles, and
    // one pause where the sender lets the output run dry.
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 50) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      if (i == 90) begin
        src_idle_pct  = 25;
        sink_idle_pct = 25;
      end
      if (i == 110) wait_for_drain();
      send_random_item();
    end
    // Close the last stream so its partial byte and total are checked too.
    send_code(32'h0000_0000, 6'd0, 1'b1);

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/msbpk_pkg.sv
hw/rtl/msbpk_in_if.sv
hw/rtl/msbpk_out_if.sv
hw/rtl/msbpk_ctrl.sv
hw/rtl/msbpk_datapath.sv
hw/rtl/msb_first_code_bit_packer_unit.sv
verif/testbench.sv
